// ===== hw/rtl/tvsg_pkg.sv =====
// shared types and register map for the three-voice sound generator
// no dependencies; imported by every module of the block
`default_nettype none

package tvsg_pkg;

  // function codes of an input request
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register map
  localparam logic [3:0] REG_TONE_BASE = 4'd0;   // lo/hi byte pairs per voice
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_BASE  = 4'd8;   // one per voice
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  localparam int unsigned OUT_VOICES = 3;
  localparam logic [16:0] NOISE_SEED = 17'h10000;
  localparam logic [3:0]  ENV_TOP    = 4'hF;

  typedef struct packed {
    logic       func;
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0] voice_a_level;
    logic       voice_a_from_env;
    logic       voice_a_gate;
    logic [3:0] voice_b_level;
    logic       voice_b_from_env;
    logic       voice_b_gate;
    logic [3:0] voice_c_level;
    logic       voice_c_from_env;
    logic       voice_c_gate;
  } out_item_t;

  // per-request control to the state units
  typedef struct packed {
    logic       wr;
    logic       tick;
    logic [3:0] addr;
    logic [7:0] data;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] level;
    logic       from_env;
    logic       gate;
  } voice_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tvsg_env.sv =====
// envelope generator: period counter, step counter and shape control
// depends on tvsg_pkg
`default_nettype none

module tvsg_env import tvsg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  output logic [3:0] env_level_o
);

  logic [15:0] period_q, period_d;
  logic [16:0] count_q, count_d;
  logic        half_q, half_d;
  logic [3:0]  step_q, step_d;
  logic        running_q, running_d;
  logic        hold_q, hold_d;
  logic        alt_q, alt_d;
  logic        invert_q, invert_d;
  logic [17:0] sum;

  always_comb begin
    period_d  = period_q;
    count_d   = count_q;
    half_d    = half_q;
    step_d    = step_q;
    running_d = running_q;
    hold_d    = hold_q;
    alt_d     = alt_q;
    invert_d  = invert_q;
    sum       = {1'b0, count_q} + 18'd2;
    if (ctrl_i.tick) begin
      half_d = ~half_q;
      if (half_d) begin
        if (sum >= {2'b00, period_q}) begin
          count_d = '0;
          if (running_q) begin
            if (step_q == 4'd0) begin
              step_d    = ENV_TOP;
              running_d = ~hold_q;
              invert_d  = invert_q ^ alt_q;
            end else begin
              step_d = step_q - 4'd1;
            end
          end
        end else begin
          count_d = sum[16:0];
        end
      end
    end else if (ctrl_i.wr) begin
      unique case (ctrl_i.addr)
        REG_ENV_LO: period_d[7:0]  = ctrl_i.data;
        REG_ENV_HI: period_d[15:8] = ctrl_i.data;
        REG_ENV_SHAPE: begin
          count_d   = '0;
          step_d    = ENV_TOP;
          running_d = 1'b1;
          invert_d  = ctrl_i.data[2];
          if (ctrl_i.data[3]) begin
            hold_d = ctrl_i.data[0];
            alt_d  = ctrl_i.data[0] ? ~ctrl_i.data[1] : ctrl_i.data[1];
          end else begin
            hold_d = 1'b1;
            alt_d  = ~ctrl_i.data[2];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      count_q   <= '0;
      half_q    <= 1'b0;
      step_q    <= ENV_TOP;
      running_q <= 1'b1;
      hold_q    <= 1'b1;
      alt_q     <= 1'b1;
      invert_q  <= 1'b0;
    end else begin
      period_q  <= period_d;
      count_q   <= count_d;
      half_q    <= half_d;
      step_q    <= step_d;
      running_q <= running_d;
      hold_q    <= hold_d;
      alt_q     <= alt_d;
      invert_q  <= invert_d;
    end
  end

  // level seen by this tick's result
  assign env_level_o = step_d ^ {4{invert_d}};

endmodule

`default_nettype wire

// ===== hw/rtl/tvsg_noise.sv =====
// 17-bit noise lfsr with its period counter
// depends on tvsg_pkg
`default_nettype none

module tvsg_noise import tvsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  output logic  noise_bit_o
);

  logic [4:0]  period_q, period_d;
  logic [5:0]  count_q, count_d;
  logic        half_q, half_d;
  logic        bit_q, bit_d;
  logic [16:0] shift_q, shift_d;
  logic [6:0]  sum;

  always_comb begin
    period_d = period_q;
    count_d  = count_q;
    half_d   = half_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    sum      = {1'b0, count_q} + 7'd2;
    if (ctrl_i.tick) begin
      half_d = ~half_q;
      if (half_d) begin
        if (sum >= {2'b00, period_q}) begin
          count_d = '0;
          bit_d   = shift_q[0];
          shift_d = {shift_q[3] ^ shift_q[0], shift_q[16:1]};
        end else begin
          count_d = sum[5:0];
        end
      end
    end else if (ctrl_i.wr && ctrl_i.addr == REG_NOISE_PER) begin
      period_d = ctrl_i.data[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      count_q  <= '0;
      half_q   <= 1'b0;
      bit_q    <= 1'b0;
      shift_q  <= NOISE_SEED;
    end else begin
      period_q <= period_d;
      count_q  <= count_d;
      half_q   <= half_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
    end
  end

  assign noise_bit_o = bit_d;

endmodule

`default_nettype wire

// ===== hw/rtl/tvsg_tone.sv =====
// one tone voice: period, counter, phase, mixer bits and volume
// depends on tvsg_pkg
`default_nettype none

module tvsg_tone import tvsg_pkg::*; #(
  parameter int unsigned VOICE_IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic       noise_bit_i,
  input  logic [3:0] env_level_i,
  output voice_t     res_o
);

  localparam logic [3:0] AddrLo  = REG_TONE_BASE + 4'(2 * VOICE_IDX);
  localparam logic [3:0] AddrHi  = REG_TONE_BASE + 4'(2 * VOICE_IDX + 1);
  localparam logic [3:0] AddrVol = REG_VOL_BASE + 4'(VOICE_IDX);

  logic [11:0] period_q, period_d;
  logic [12:0] count_q, count_d;
  logic        phase_q, phase_d;
  logic        tone_off_q, tone_off_d;
  logic        noise_off_q, noise_off_d;
  logic [3:0]  vol_q, vol_d;
  logic        use_env_q, use_env_d;
  logic [13:0] sum;

  always_comb begin
    period_d    = period_q;
    count_d     = count_q;
    phase_d     = phase_q;
    tone_off_d  = tone_off_q;
    noise_off_d = noise_off_q;
    vol_d       = vol_q;
    use_env_d   = use_env_q;
    sum         = {1'b0, count_q} + 14'd2;
    if (ctrl_i.tick) begin
      if (sum >= {2'b00, period_q}) begin
        count_d = '0;
        phase_d = ~phase_q;
      end else begin
        count_d = sum[12:0];
      end
    end else if (ctrl_i.wr) begin
      if (ctrl_i.addr == AddrLo) period_d[7:0] = ctrl_i.data;
      if (ctrl_i.addr == AddrHi) period_d[11:8] = ctrl_i.data[3:0];
      if (ctrl_i.addr == AddrVol) begin
        vol_d     = ctrl_i.data[3:0];
        use_env_d = ctrl_i.data[4];
      end
      if (ctrl_i.addr == REG_MIXER) begin
        tone_off_d  = ctrl_i.data[VOICE_IDX];
        noise_off_d = ctrl_i.data[VOICE_IDX + 3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= '0;
      count_q     <= '0;
      phase_q     <= 1'b0;
      tone_off_q  <= 1'b0;
      noise_off_q <= 1'b0;
      vol_q       <= '0;
      use_env_q   <= 1'b0;
    end else begin
      period_q    <= period_d;
      count_q     <= count_d;
      phase_q     <= phase_d;
      tone_off_q  <= tone_off_d;
      noise_off_q <= noise_off_d;
      vol_q       <= vol_d;
      use_env_q   <= use_env_d;
    end
  end

  assign res_o.level    = use_env_q ? env_level_i : vol_q;
  assign res_o.from_env = use_env_q;
  assign res_o.gate     = (phase_d | tone_off_q) & (noise_bit_i | noise_off_q);

endmodule

`default_nettype wire

// ===== hw/rtl/three_voice_sound_generator_unit.sv =====
// three-voice square-wave sound generator, top level
// a tick request shows its result in the cycle after acceptance; writes give none
// throughput: one request per cycle, writes and ticks in any mix, while the result register is free
// or being taken; set by the single state-update pass and the one-entry result register
// reset (rst_ni, async, active low) clears all state but the result payload: envelope at step 15, lfsr seeded
`default_nettype none

module three_voice_sound_generator_unit import tvsg_pkg::*; #(
  parameter int unsigned VOICES = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // voices past the third are never addressed and never reported
  localparam int unsigned Lanes = (VOICES < OUT_VOICES) ? VOICES : OUT_VOICES;

  logic      accept;
  ctrl_t     ctrl;
  logic      noise_bit;
  logic [3:0] env_level;
  voice_t    res [OUT_VOICES];
  out_item_t out_d, out_q;
  logic      out_valid_q, out_valid_d;

  // the result register frees up in the same cycle it is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // request decode
  assign ctrl.wr   = accept && (in_data_i.func == FUNC_WRITE);
  assign ctrl.tick = accept && (in_data_i.func == FUNC_TICK);
  assign ctrl.addr = in_data_i.reg_addr;
  assign ctrl.data = in_data_i.reg_data;

  // envelope and noise run ahead of the voices; their next values feed the mix
  tvsg_env u_env (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .env_level_o (env_level)
  );

  tvsg_noise u_noise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .noise_bit_o (noise_bit)
  );

  // one tone lane per voice; missing voices report zeros
  for (genvar v = 0; v < OUT_VOICES; v++) begin : g_voice
    if (v < Lanes) begin : g_lane
      tvsg_tone #(
        .VOICE_IDX (v)
      ) u_tone (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .noise_bit_i (noise_bit),
        .env_level_i (env_level),
        .res_o       (res[v])
      );
    end else begin : g_none
      assign res[v] = '0;
    end
  end

  // result assembly
  always_comb begin
    out_d.voice_a_level    = res[0].level;
    out_d.voice_a_from_env = res[0].from_env;
    out_d.voice_a_gate     = res[0].gate;
    out_d.voice_b_level    = res[1].level;
    out_d.voice_b_from_env = res[1].from_env;
    out_d.voice_b_gate     = res[1].gate;
    out_d.voice_c_level    = res[2].level;
    out_d.voice_c_from_env = res[2].from_env;
    out_d.voice_c_gate     = res[2].gate;
  end

  // result valid: set by a tick, cleared once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on a tick
  always_ff @(posedge clk_i) begin
    if (ctrl.tick) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a tick request always produces a result in the next cycle
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_TICK |=> out_valid_o)
    else $error("tick request produced no result");

  // a register write never creates a result out of nothing
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_WRITE && !out_valid_o
    |=> !out_valid_o)
    else $error("register write produced a result");

  // voices a and b, when both on the envelope, see the same envelope level
  a_env_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.voice_a_from_env && out_data_o.voice_b_from_env
    |-> out_data_o.voice_a_level == out_data_o.voice_b_level)
    else $error("envelope voices disagree on level");

endmodule

`default_nettype wire
